@@ rtl/ascm_pkg.sv @@
// Shared types and constants for the adaptive sample convergence monitor.
// No dependencies; imported by every module of the block.
package ascm_pkg;

  // Defaults for the top-level parameters
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int WARMUP_DEF      = 64;

  // Field and datapath widths
  localparam int DC_W        = 16;          // signed Q3.12 input component
  localparam int CFG_W       = 16;          // config data width
  localparam int COUNT_OUT_W = 16;          // count_now width
  localparam int MEAN_W      = 32;          // mean_now width (Q16.16)
  localparam int LUM_W       = 20;          // luminance / mean magnitude bits
  localparam int RAD_W       = 2 * LUM_W;   // root radicand: sum of squares << 8
  localparam int PROD_W      = 2 * LUM_W;   // |delta| * |delta2|
  localparam int M2_W        = 48;          // Welford M2 (Q16.32)
  localparam int TOL_W       = CFG_W + LUM_W;
  localparam int TSQ_W       = 2 * TOL_W;
  localparam int LIMB_W      = 32;          // shared multiplier operand width
  localparam int ACC_W       = TSQ_W + 2 * LIMB_W;

  // Root and divide loops retire two bits per cycle
  localparam int ITERS  = LUM_W / 2;
  localparam int ITER_W = $clog2(ITERS);

  // Tolerance floor: 1e-4 in Q.32
  localparam logic [TOL_W-1:0] TOL_FLOOR = TOL_W'(429497);

  // Config reset values
  localparam logic [CFG_W-1:0] SAMPLE_LIMIT_RST = CFG_W'(1024);
  localparam logic [CFG_W-1:0] CONF_THRESH_RST  = CFG_W'(655);

  typedef enum logic [1:0] {
    REASON_CONT = 2'd0,
    REASON_MAX  = 2'd1,
    REASON_CONV = 2'd2
  } reason_t;

  typedef enum logic {
    REG_SAMPLE_LIMIT = 1'b0,
    REG_CONF_THRESH  = 1'b1
  } cfg_reg_t;

  // One request to the shared multiply-accumulate unit
  typedef struct packed {
    logic              valid;
    logic              first;   // load instead of accumulate
    logic [1:0]        shift;   // product weight in limbs
    logic [LIMB_W-1:0] a;
    logic [LIMB_W-1:0] b;
  } mac_req_t;

endpackage

@@ rtl/ascm_isqrt.sv @@
// Iterative integer square root, two result bits per cycle.
// Depends on ascm_pkg for widths and iteration count.
module ascm_isqrt
  import ascm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RAD_W-1:0] radicand,
  output logic             done,
  output logic [LUM_W-1:0] root
);

  localparam int RW = LUM_W + 3;

  typedef struct packed {
    logic [RW-1:0]    rem;
    logic [LUM_W-1:0] root;
  } sq_state_t;

  logic              running;
  logic [ITER_W-1:0] iter;
  logic [RAD_W-1:0]  rad;
  logic [RW-1:0]     rem;
  sq_state_t         s0, s1, s2;

  // one digit of the restoring root
  function automatic sq_state_t sq_step(sq_state_t cur, logic [1:0] bits);
    sq_state_t     nxt;
    logic [RW-1:0] shifted;
    logic [RW-1:0] trial;
    shifted = {cur.rem[RW-3:0], bits};
    trial   = RW'({cur.root, 2'b01});
    if (shifted >= trial) begin
      nxt.rem  = shifted - trial;
      nxt.root = {cur.root[LUM_W-2:0], 1'b1};
    end else begin
      nxt.rem  = shifted;
      nxt.root = {cur.root[LUM_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // two digits per cycle, top radicand bits first
  always_comb begin
    s0.rem  = rem;
    s0.root = root;
    s1 = sq_step(s0, rad[RAD_W-1 -: 2]);
    s2 = sq_step(s1, rad[RAD_W-3 -: 2]);
  end

  // loop control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        iter    <= ITER_W'(ITERS - 1);
      end else if (running) begin
        if (iter == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        iter <= iter - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (running) begin
      rad  <= rad << 4;
      rem  <= s2.rem;
      root <= s2.root;
    end
  end

endmodule

@@ rtl/ascm_div.sv @@
// Iterative restoring divider, two quotient bits per cycle.
// Depends on ascm_pkg for widths and iteration count.
module ascm_div
  import ascm_pkg::*;
#(
  parameter int DW = COUNT_WIDTH_DEF
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [LUM_W-1:0] dividend,
  input  logic [DW-1:0]    divisor,
  output logic             done,
  output logic [LUM_W-1:0] quotient
);

  typedef struct packed {
    logic [DW-1:0]    rem;
    logic [LUM_W-1:0] quo;
  } dv_state_t;

  logic              running;
  logic [ITER_W-1:0] iter;
  logic [LUM_W-1:0]  num;
  logic [DW-1:0]     dvs;
  logic [DW-1:0]     rem;
  dv_state_t         s0, s1, s2;

  // one restoring step
  function automatic dv_state_t dv_step(dv_state_t cur, logic nbit, logic [DW-1:0] d);
    dv_state_t   nxt;
    logic [DW:0] rs;
    rs = {cur.rem, nbit};
    if (rs >= {1'b0, d}) begin
      rs      = rs - {1'b0, d};
      nxt.quo = {cur.quo[LUM_W-2:0], 1'b1};
    end else begin
      nxt.quo = {cur.quo[LUM_W-2:0], 1'b0};
    end
    nxt.rem = rs[DW-1:0];
    return nxt;
  endfunction

  always_comb begin
    s0.rem = rem;
    s0.quo = quotient;
    s1 = dv_step(s0, num[LUM_W-1], dvs);
    s2 = dv_step(s1, num[LUM_W-2], dvs);
  end

  // loop control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      iter    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        iter    <= ITER_W'(ITERS - 1);
      end else if (running) begin
        if (iter == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
        iter <= iter - 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (running) begin
      num      <= num << 2;
      rem      <= s2.rem;
      quotient <= s2.quo;
    end
  end

endmodule

@@ rtl/ascm_mac.sv @@
// Shared 32x32 multiply-accumulate unit with limb-weighted accumulation.
// Depends on ascm_pkg for mac_req_t and widths.
module ascm_mac
  import ascm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  mac_req_t         req,
  output logic             busy,
  output logic [ACC_W-1:0] acc
);

  logic [2*LIMB_W-1:0] prod;
  logic                p_valid;
  logic                p_first;
  logic [1:0]          p_shift;
  logic [ACC_W-1:0]    addend;

  // align product to its limb weight
  assign addend = ACC_W'(prod) << (LIMB_W * p_shift);
  assign busy   = p_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= req.valid;
    end
  end

  // product stage, then accumulate stage
  always_ff @(posedge clk) begin
    if (req.valid) begin
      prod    <= req.a * req.b;
      p_first <= req.first;
      p_shift <= req.shift;
    end
    if (p_valid) begin
      acc <= p_first ? addend : acc + addend;
    end
  end

endmodule

@@ rtl/adaptive_sample_convergence_monitor_top.sv @@
// Adaptive sample convergence monitor: one result per sample, on valid/stall channels.
// A result is loaded once the sequence reaches S_DONE and the output register is free,
// and the next request can be taken in S_IDLE after that. The stop test (tolerance,
// its square, n*(n-1) and the final product) runs as well once the count has reached
// the warm-up and is below the sample limit. The time is set by the square root and
// the mean update divide (ten two-bit iterations each, then a done strobe) and by the
// single shared 32x32 multiply-accumulate unit that forms every product. The input
// side stalls while an item is in work; a finished result waits in the output
// register, and the next request is taken while it does.
// Config writes take effect at once and are meant for idle periods.
// Depends on ascm_pkg, ascm_mac, ascm_isqrt and ascm_div.
module adaptive_sample_convergence_monitor_top
  import ascm_pkg::*;
#(
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int WARMUP_SAMPLES = WARMUP_DEF
)
(
  input  logic                   clk,
  input  logic                   rst,
  // config write port
  input  logic                   cfg_write_en,
  input  logic                   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  // sample request channel
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic signed [DC_W-1:0] dc_red,
  input  logic signed [DC_W-1:0] dc_green,
  input  logic signed [DC_W-1:0] dc_blue,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   want_more,
  output logic [1:0]             stop_reason,
  output logic [COUNT_OUT_W-1:0] count_now,
  output logic [MEAN_W-1:0]      mean_now
);

  localparam int K_W = 2 * COUNT_WIDTH;

  typedef enum logic [4:0] {
    S_IDLE, S_SUMSQ, S_SUMSQ_WAIT, S_ROOT, S_DIV, S_PROD, S_PROD_WAIT, S_DECIDE,
    S_TOL, S_TOL_WAIT, S_TSQ, S_TSQ_WAIT, S_K, S_K_WAIT, S_PRD, S_PRD_WAIT, S_DONE
  } state_t;

  state_t                  state;
  logic [2:0]              step;
  reason_t                 reason;

  logic [CFG_W-1:0]        sample_limit;
  logic [CFG_W-1:0]        conf_thresh;
  logic [COUNT_WIDTH-1:0]  cnt;
  logic [LUM_W-1:0]        mean;
  logic [M2_W-1:0]         m2;

  logic [DC_W-1:0]         mag_r, mag_g, mag_b;
  logic [LUM_W-1:0]        lum;
  logic [LUM_W-1:0]        dmag;
  logic                    dneg;
  logic                    prod_neg;
  logic [TOL_W-1:0]        tol;
  logic [TSQ_W-1:0]        tsq;
  logic [K_W-1:0]          k;

  mac_req_t                mac_req;
  logic                    mac_busy;
  logic [ACC_W-1:0]        acc;

  logic                    root_start, root_done;
  logic [LUM_W-1:0]        root_out;
  logic [RAD_W-1:0]        radicand;
  logic                    div_start, div_done;
  logic [LUM_W-1:0]        quot;

  logic [COUNT_WIDTH-1:0]  cnt_inc;
  logic [LUM_W:0]          d_diff, d2_diff;
  logic                    d_neg_c, d2_neg;
  logic [LUM_W-1:0]        d_mag_c, d2_mag;
  logic [LUM_W-1:0]        mean_new;
  logic signed [M2_W+1:0]  m2_sum;
  logic [M2_W-1:0]         m2_new;
  logic [TOL_W-1:0]        tol_raw;
  logic [M2_W+3:0]         nine_m2;
  logic [ACC_W-1:0]        lhs;
  logic                    conv;
  logic                    at_max, warm;
  logic [DC_W-1:0]         sq_mag;
  logic [LIMB_W-1:0]       tl, th;
  logic [LIMB_W-1:0]       tsq_limb, k_limb;
  logic [2*LIMB_W-1:0]     k_ext;

  function automatic logic [DC_W-1:0] mag16(logic signed [DC_W-1:0] v);
    return v[DC_W-1] ? DC_W'(-v) : DC_W'(v);
  endfunction

  // shared arithmetic units
  ascm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .req  (mac_req),
    .busy (mac_busy),
    .acc  (acc)
  );

  ascm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root_out)
  );

  ascm_div #(.DW(COUNT_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (d_mag_c),
    .divisor  (cnt),
    .done     (div_done),
    .quotient (quot)
  );

  assign sample_stall = rst || (state != S_IDLE);

  // luminance = sqrt(sum of squares << 8)
  assign radicand   = {acc[2*DC_W-1:0], {(RAD_W - 2*DC_W){1'b0}}};
  assign root_start = (state == S_SUMSQ_WAIT) && !mac_busy;
  assign div_start  = (state == S_ROOT) && root_done;

  // saturating count
  assign cnt_inc = (cnt == {COUNT_WIDTH{1'b1}}) ? cnt : cnt + 1'b1;

  // delta against the old mean, mean update, delta2 against the new mean
  assign d_diff   = {1'b0, root_out} - {1'b0, mean};
  assign d_neg_c  = d_diff[LUM_W];
  assign d_mag_c  = d_neg_c ? LUM_W'(-d_diff) : d_diff[LUM_W-1:0];
  assign mean_new = dneg ? mean - quot : mean + quot;
  assign d2_diff  = {1'b0, lum} - {1'b0, mean};
  assign d2_neg   = d2_diff[LUM_W];
  assign d2_mag   = d2_neg ? LUM_W'(-d2_diff) : d2_diff[LUM_W-1:0];

  // M2 update with clamp to [0, 2^48-1]
  assign m2_sum = prod_neg ? $signed({2'b00, m2}) - $signed((M2_W+2)'(acc[PROD_W-1:0]))
                           : $signed({2'b00, m2}) + $signed((M2_W+2)'(acc[PROD_W-1:0]));
  always_comb begin
    if (m2_sum[M2_W+1]) begin
      m2_new = '0;
    end else if (m2_sum[M2_W]) begin
      m2_new = {M2_W{1'b1}};
    end else begin
      m2_new = m2_sum[M2_W-1:0];
    end
  end

  // stop test pieces
  assign tol_raw = acc[TOL_W-1:0];
  assign nine_m2 = {m2, 3'b000} + {4'b0000, m2};
  assign lhs     = ACC_W'({nine_m2, {LIMB_W{1'b0}}});
  assign conv    = lhs < acc;
  assign at_max  = 33'(cnt) >= 33'(sample_limit);
  assign warm    = 33'(cnt) >= 33'(WARMUP_SAMPLES);

  // operand selection for the shared multiplier
  assign tl    = tol[LIMB_W-1:0];
  assign th    = LIMB_W'(tol[TOL_W-1:LIMB_W]);
  assign k_ext = (2*LIMB_W)'(k);

  always_comb begin
    case (step)
      3'd0:    sq_mag = mag_r;
      3'd1:    sq_mag = mag_g;
      default: sq_mag = mag_b;
    endcase
    case (step[2:1])
      2'd0:    tsq_limb = tsq[LIMB_W-1:0];
      2'd1:    tsq_limb = tsq[2*LIMB_W-1:LIMB_W];
      default: tsq_limb = LIMB_W'(tsq[TSQ_W-1:2*LIMB_W]);
    endcase
    k_limb = step[0] ? k_ext[2*LIMB_W-1:LIMB_W] : k_ext[LIMB_W-1:0];
  end

  always_comb begin
    mac_req = '0;
    case (state)
      S_SUMSQ: begin
        mac_req.valid = 1'b1;
        mac_req.first = (step == 3'd0);
        mac_req.a     = LIMB_W'(sq_mag);
        mac_req.b     = LIMB_W'(sq_mag);
      end
      S_PROD: begin
        mac_req.valid = 1'b1;
        mac_req.first = 1'b1;
        mac_req.a     = LIMB_W'(dmag);
        mac_req.b     = LIMB_W'(d2_mag);
      end
      S_TOL: begin
        mac_req.valid = 1'b1;
        mac_req.first = 1'b1;
        mac_req.a     = LIMB_W'(conf_thresh);
        mac_req.b     = LIMB_W'(mean);
      end
      S_TSQ: begin
        mac_req.valid = 1'b1;
        mac_req.first = (step == 3'd0);
        case (step)
          3'd0: begin
            mac_req.a = tl; mac_req.b = tl; mac_req.shift = 2'd0;
          end
          3'd1: begin
            mac_req.a = tl; mac_req.b = th; mac_req.shift = 2'd1;
          end
          3'd2: begin
            mac_req.a = th; mac_req.b = tl; mac_req.shift = 2'd1;
          end
          default: begin
            mac_req.a = th; mac_req.b = th; mac_req.shift = 2'd2;
          end
        endcase
      end
      S_K: begin
        mac_req.valid = 1'b1;
        mac_req.first = 1'b1;
        mac_req.a     = LIMB_W'(cnt);
        mac_req.b     = LIMB_W'(cnt - 1'b1);
      end
      S_PRD: begin
        mac_req.valid = 1'b1;
        mac_req.first = (step == 3'd0);
        mac_req.a     = tsq_limb;
        mac_req.b     = k_limb;
        mac_req.shift = 2'(step[2:1]) + 2'(step[0]);
      end
      default: mac_req = '0;
    endcase
  end

  // sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      result_valid <= 1'b0;
      sample_limit <= SAMPLE_LIMIT_RST;
      conf_thresh  <= CONF_THRESH_RST;
      cnt          <= '0;
      mean         <= '0;
      m2           <= '0;
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          REG_SAMPLE_LIMIT: sample_limit <= cfg_data;
          REG_CONF_THRESH:  conf_thresh  <= cfg_data;
          default: ;
        endcase
      end

      // drain; in S_DONE the load below decides result_valid
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            mag_r <= mag16(dc_red);
            mag_g <= mag16(dc_green);
            mag_b <= mag16(dc_blue);
            cnt   <= cnt_inc;
            step  <= '0;
            state <= S_SUMSQ;
          end
        end
        S_SUMSQ: begin
          if (step == 3'd2) begin
            step  <= '0;
            state <= S_SUMSQ_WAIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SUMSQ_WAIT: begin
          if (!mac_busy) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            lum   <= root_out;
            dmag  <= d_mag_c;
            dneg  <= d_neg_c;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            mean  <= mean_new;
            state <= S_PROD;
          end
        end
        S_PROD: begin
          prod_neg <= dneg ^ d2_neg;
          state    <= S_PROD_WAIT;
        end
        S_PROD_WAIT: begin
          if (!mac_busy) begin
            m2    <= m2_new;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (at_max) begin
            reason <= REASON_MAX;
            state  <= S_DONE;
          end else if (warm) begin
            state <= S_TOL;
          end else begin
            reason <= REASON_CONT;
            state  <= S_DONE;
          end
        end
        S_TOL: state <= S_TOL_WAIT;
        S_TOL_WAIT: begin
          if (!mac_busy) begin
            tol   <= (tol_raw < TOL_FLOOR) ? TOL_FLOOR : tol_raw;
            step  <= '0;
            state <= S_TSQ;
          end
        end
        S_TSQ: begin
          if (step == 3'd3) begin
            step  <= '0;
            state <= S_TSQ_WAIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_TSQ_WAIT: begin
          if (!mac_busy) begin
            tsq   <= acc[TSQ_W-1:0];
            state <= S_K;
          end
        end
        S_K: state <= S_K_WAIT;
        S_K_WAIT: begin
          if (!mac_busy) begin
            k     <= acc[K_W-1:0];
            step  <= '0;
            state <= S_PRD;
          end
        end
        S_PRD: begin
          if (step == 3'd5) begin
            step  <= '0;
            state <= S_PRD_WAIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_PRD_WAIT: begin
          if (!mac_busy) begin
            reason <= conv ? REASON_CONV : REASON_CONT;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          // load the output register once it is free or being drained
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            want_more    <= (reason == REASON_CONT);
            stop_reason  <= reason;
            count_now    <= COUNT_OUT_W'(cnt);
            mean_now     <= MEAN_W'(mean);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ascm_checker.sv @@
// Port-level checks for the convergence monitor, bound to the top level.
// Depends on ascm_pkg and adaptive_sample_convergence_monitor_top.
module ascm_checker
  import ascm_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   sample_valid,
  input logic                   sample_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input logic                   want_more,
  input logic [1:0]             stop_reason,
  input logic [COUNT_OUT_W-1:0] count_now,
  input logic [MEAN_W-1:0]      mean_now
);

  // block is busy in the cycle after it takes a request
  a_busy_after_request: assert property (
    @(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall
  ) else $error("sample channel not stalled after a request");

  // no result pending right after reset
  a_reset_clears_result: assert property (
    @(posedge clk) rst |=> !result_valid
  ) else $error("result valid right after reset");

  // want_more set exactly when the reason is continue
  a_reason_matches: assert property (
    @(posedge clk) disable iff (rst)
    result_valid |-> (want_more == (stop_reason == REASON_CONT))
  ) else $error("want_more and stop_reason disagree");

  // mean never exceeds the luminance range
  a_mean_range: assert property (
    @(posedge clk) disable iff (rst)
    result_valid |-> (mean_now[MEAN_W-1:LUM_W] == '0)
  ) else $error("mean outside luminance range");

  // a stalled result holds
  a_result_holds: assert property (
    @(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(count_now) && $stable(mean_now) && $stable(stop_reason))
  ) else $error("stalled result changed");

endmodule

bind adaptive_sample_convergence_monitor_top ascm_checker u_ascm_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .want_more    (want_more),
  .stop_reason  (stop_reason),
  .count_now    (count_now),
  .mean_now     (mean_now)
);
